// File: rtl/rpn_pkg.sv
package rpn_pkg;

    localparam int STACK_DEPTH = 16;

    typedef enum logic [3:0] {
        OP_PUSH     = 4'd0,
        OP_ADD      = 4'd1,
        OP_SUB      = 4'd2,
        OP_MUL      = 4'd3,
        OP_DIV      = 4'd4,
        OP_NEG      = 4'd5,
        OP_DUP      = 4'd6,
        OP_SWAP     = 4'd7,
        OP_PRINT    = 4'd8,
        OP_CLEAR    = 4'd9,
        OP_PRINTALL = 4'd10,
        OP_INVALID  = 4'd11
    } op_t;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_FEW  = 3'd1;
    localparam logic [2:0] ST_DIV0 = 3'd2;
    localparam logic [2:0] ST_BAD  = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    // Per-cycle command to every stack cell
    typedef enum logic [2:0] {
        SH_HOLD  = 3'd0,
        SH_PUSH  = 3'd1,  // take from upper neighbor (toward top), top loads new value
        SH_POP   = 3'd2,  // take from lower neighbor
        SH_LDTOP = 3'd3,  // top cell loads new value, rest hold
        SH_SWAP  = 3'd4,  // top two exchange
        SH_ROT   = 3'd5   // live region moves up one, top wraps to the tail (print all walk)
    } shift_t;

    typedef struct packed {
        shift_t      op;
        logic [31:0] data;
    } cell_ctl_t;

endpackage

// File: rtl/rpn_cell.sv
// One stack slot; index 0 is the top of stack.
module rpn_cell
    import rpn_pkg::*;
(
    input  logic        aclk,
    input  cell_ctl_t   ctl,
    input  logic        is_top,
    input  logic        is_second,
    input  logic        is_tail,    // deepest live entry
    input  logic [31:0] up_data,    // cell nearer the top
    input  logic [31:0] down_data,  // cell further from the top
    input  logic [31:0] wrap_data,  // rotation source for the tail cell
    output logic [31:0] q
);
    logic [31:0] data_reg, data_next;

    always_comb begin
        data_next = data_reg;
        case (ctl.op)
            SH_PUSH:  data_next = is_top ? ctl.data : up_data;
            SH_POP:   data_next = is_top ? ctl.data : down_data;
            SH_LDTOP: if (is_top) data_next = ctl.data;
            SH_SWAP: begin
                if (is_top) data_next = down_data;
                else if (is_second) data_next = up_data;
            end
            SH_ROT:   data_next = is_tail ? wrap_data : down_data;
            default:  data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;
endmodule

// File: rtl/rpn_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
module rpn_div
    import rpn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quo
);
    logic [31:0] rem_reg, q_reg, d_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg, busy_reg, done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg, q_reg[31]} - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                rem_reg  <= '0;
                q_reg    <= num[31] ? (32'd0 - num) : num;
                d_reg    <= den[31] ? (32'd0 - den) : den;
                neg_reg  <= num[31] ^ den[31];
            end else if (busy_reg) begin
                if (trial[32]) begin
                    rem_reg <= {rem_reg[30:0], q_reg[31]};
                    q_reg   <= {q_reg[30:0], 1'b0};
                end else begin
                    rem_reg <= trial[31:0];
                    q_reg   <= {q_reg[30:0], 1'b1};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? (32'd0 - q_reg) : q_reg;
endmodule

// File: rtl/rpn_stack_calculator_core.sv
// Reverse Polish calculator on a 16-slot shift-register stack.
// Each command is latched in S_IDLE and executed in S_EXEC; divide waits in S_WAIT on
// the 32-step divider and multiply stays in S_EXEC for the registered product.
// Print all emits one beat per entry, one per cycle while m_ready holds. One command
// is handled at a time: the next is accepted the cycle after the last result beat is taken.
// aresetn (synchronous, active low) empties the stack; slot contents are not cleared.
module rpn_stack_calculator_core
    import rpn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_mode,
    input  logic signed [31:0] s_push_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_has_value,
    output logic signed [31:0] m_value,
    output logic [4:0]  m_depth_now,
    output logic        m_last
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_WAIT = 5'b00100,
        S_OUT  = 5'b01000,
        S_WALK = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0]  mode_reg;
    logic [31:0] pv_reg;
    logic [4:0]  cnt_reg;
    logic [4:0]  walk_reg;     // entries left to print
    logic [31:0] prod_reg;
    logic        mul_ph_reg;
    logic        m_valid_reg;
    logic [2:0]  o_status_reg;
    logic        o_hv_reg, o_last_reg;
    logic [31:0] o_value_reg;
    logic [4:0]  o_depth_reg;

    logic [31:0] q [STACK_DEPTH];
    cell_ctl_t   ctl;
    logic        div_start, div_done;
    logic [31:0] div_q;
    logic [31:0] top, sec;
    assign top = q[0];
    assign sec = q[1];

    // Stack row
    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            rpn_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .is_top    (g == 0),
                .is_second (g == 1),
                .is_tail   (cnt_reg == 5'(g + 1)),
                .up_data   (q[(g == 0) ? 0 : g - 1]),
                .down_data (q[(g == STACK_DEPTH - 1) ? g : g + 1]),
                .wrap_data (top),
                .q         (q[g])
            );
        end
    endgenerate

    rpn_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(sec), .den(top), .done(div_done), .quo(div_q)
    );

    assign s_ready = (state_reg == S_IDLE);

    // Command execution and result staging
    always_comb begin
        state_next = state_reg;
        ctl.op     = SH_HOLD;
        ctl.data   = top;
        div_start  = 1'b0;
        if (state_reg == S_EXEC) begin
            state_next = S_OUT;
            case (mode_reg)
                OP_PUSH: if (cnt_reg != 5'(STACK_DEPTH)) begin
                    ctl.op = SH_PUSH; ctl.data = pv_reg;
                end
                OP_ADD: if (cnt_reg >= 5'd2) begin
                    ctl.op = SH_POP; ctl.data = sec + top;
                end
                OP_SUB: if (cnt_reg >= 5'd2) begin
                    ctl.op = SH_POP; ctl.data = sec - top;
                end
                OP_MUL: if (cnt_reg >= 5'd2) begin
                    if (!mul_ph_reg) state_next = S_EXEC;
                    else begin
                        ctl.op = SH_POP; ctl.data = prod_reg;
                    end
                end
                OP_DIV: if (cnt_reg >= 5'd2 && top != 32'd0) begin
                    div_start = 1'b1; state_next = S_WAIT;
                end
                OP_NEG: if (cnt_reg >= 5'd1) begin
                    ctl.op = SH_LDTOP; ctl.data = 32'd0 - top;
                end
                OP_DUP: if (cnt_reg >= 5'd1 && cnt_reg != 5'(STACK_DEPTH)) begin
                    ctl.op = SH_PUSH; ctl.data = top;
                end
                OP_SWAP: if (cnt_reg >= 5'd2) ctl.op = SH_SWAP;
                OP_PRINTALL: if (cnt_reg != 5'd0) state_next = S_WALK;
                default: ;
            endcase
        end else if (state_reg == S_WAIT) begin
            if (div_done) begin
                ctl.op = SH_POP; ctl.data = div_q; state_next = S_OUT;
            end
        end else if (state_reg == S_WALK && walk_reg != 5'd0
                     && (m_ready || !m_valid_reg)) begin
            // rotate: each emitted top moves to bottom of live region
            ctl.op = SH_ROT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            mul_ph_reg  <= 1'b0;
            walk_reg    <= '0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_valid) begin
                    mode_reg   <= s_mode;
                    pv_reg     <= s_push_value;
                    mul_ph_reg <= 1'b0;
                    state_reg  <= S_EXEC;
                end
                S_EXEC: begin
                    prod_reg   <= sec * top;
                    mul_ph_reg <= 1'b1;
                    state_reg  <= state_next;
                    o_hv_reg   <= 1'b0;
                    o_value_reg <= '0;
                    o_last_reg <= 1'b1;
                    o_status_reg <= ST_OK;
                    o_depth_reg <= cnt_reg;
                    walk_reg   <= cnt_reg;
                    case (mode_reg)
                        OP_PUSH: if (cnt_reg == 5'(STACK_DEPTH)) o_status_reg <= ST_FULL;
                            else begin
                                cnt_reg <= cnt_reg + 5'd1; o_depth_reg <= cnt_reg + 5'd1;
                            end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                            if (cnt_reg < 5'd2) o_status_reg <= ST_FEW;
                            else if (mode_reg == OP_DIV && top == 32'd0)
                                o_status_reg <= ST_DIV0;
                            else if (state_next == S_OUT) begin
                                cnt_reg <= cnt_reg - 5'd1; o_depth_reg <= cnt_reg - 5'd1;
                            end
                        OP_NEG, OP_SWAP:
                            if (cnt_reg < ((mode_reg == OP_SWAP) ? 5'd2 : 5'd1))
                                o_status_reg <= ST_FEW;
                        OP_DUP: if (cnt_reg == 5'd0) o_status_reg <= ST_FEW;
                            else if (cnt_reg == 5'(STACK_DEPTH)) o_status_reg <= ST_FULL;
                            else begin
                                cnt_reg <= cnt_reg + 5'd1; o_depth_reg <= cnt_reg + 5'd1;
                            end
                        OP_PRINT: if (cnt_reg == 5'd0) o_status_reg <= ST_FEW;
                            else begin
                                o_hv_reg <= 1'b1; o_value_reg <= top;
                            end
                        OP_CLEAR: begin
                            cnt_reg <= '0; o_depth_reg <= '0;
                        end
                        OP_PRINTALL: ;
                        default: o_status_reg <= ST_BAD;
                    endcase
                    if (state_next == S_OUT) m_valid_reg <= 1'b1;
                end
                S_WAIT: if (div_done) begin
                    cnt_reg     <= cnt_reg - 5'd1;
                    o_depth_reg <= cnt_reg - 5'd1;
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_OUT: if (m_valid_reg && m_ready) state_reg <= S_IDLE;
                S_WALK: if (!m_valid_reg || m_ready) begin
                    if (walk_reg == 5'd0) state_reg <= S_IDLE;
                    else begin
                        m_valid_reg  <= 1'b1;
                        o_hv_reg     <= 1'b1;
                        o_value_reg  <= top;
                        o_status_reg <= ST_OK;
                        o_last_reg   <= (walk_reg == 5'd1);
                        walk_reg     <= walk_reg - 5'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = o_status_reg;
    assign m_has_value = o_hv_reg;
    assign m_value     = o_value_reg;
    assign m_depth_now = o_depth_reg;
    assign m_last      = o_last_reg;

`ifndef NO_ASSERTIONS
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 5'(STACK_DEPTH)) else $error("stack count overflow");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !m_valid_reg) else $error("result pending while idle");
    a_hv_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_value |-> m_status == ST_OK) else $error("printed value with error");
`endif
endmodule
